### rtl/vrcs_pkg.sv
// vrcs_pkg: shared types, constants and the cordic angle table
// for the velocity ramp with collision stop block; no dependencies
`default_nettype none
package vrcs_pkg;

  localparam int TableLen = 24;
  localparam logic [16:0] HalfTurn = 17'd32768;
  localparam logic [16:0] QuarterTurn = 17'd16384;
  localparam logic [15:0] GainInvQ16 = 16'd39797;

  typedef enum logic [2:0] {
    REG_SPEED_CAP  = 3'd0,
    REG_SPEED_STEP = 3'd1,
    REG_STOP_SPEED = 3'd2,
    REG_NEAR_DIST  = 3'd3,
    REG_MOVING     = 3'd4,
    REG_CONE       = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_TGT,
    ST_PLR,
    ST_SPEED,
    ST_ROT,
    ST_FIN,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sq_start;
    logic sqrt_start;
    logic vec_tgt_start;
    logic vec_plr_start;
    logic speed_calc;
    logic rot_start;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
    logic collision;
    logic near_moving;
  } stat_t;

  function automatic logic [15:0] atan_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd8192;
      5'd1: v = 16'd4836;
      5'd2: v = 16'd2555;
      5'd3: v = 16'd1297;
      5'd4: v = 16'd651;
      5'd5: v = 16'd326;
      5'd6: v = 16'd163;
      5'd7: v = 16'd81;
      5'd8: v = 16'd41;
      5'd9: v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/vrcs_ctrl.sv
// vrcs_ctrl: sequencing state machine for one control tick
// depends on vrcs_pkg
`default_nettype none
module vrcs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_fire,
  input  wire logic           out_free,
  input  wire logic           coll_active,
  input  vrcs_pkg::stat_t     stat,
  output vrcs_pkg::cmd_t      cmd,
  output logic                busy
);

  vrcs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= vrcs_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      vrcs_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = vrcs_pkg::ST_SQ;
        end
      end
      vrcs_pkg::ST_SQ: begin
        cmd.sq_start = 1'b1;
        state_nxt = vrcs_pkg::ST_SQRT;
      end
      vrcs_pkg::ST_SQRT: begin
        if (stat.sqrt_done) begin
          if (coll_active) begin
            state_nxt = vrcs_pkg::ST_SPEED;
          end else begin
            cmd.vec_tgt_start = 1'b1;
            state_nxt = vrcs_pkg::ST_TGT;
          end
        end
      end
      vrcs_pkg::ST_TGT: begin
        if (stat.cordic_done) begin
          if (stat.near_moving) begin
            cmd.vec_plr_start = 1'b1;
            state_nxt = vrcs_pkg::ST_PLR;
          end else begin
            state_nxt = vrcs_pkg::ST_SPEED;
          end
        end
      end
      vrcs_pkg::ST_PLR: begin
        if (stat.cordic_done) state_nxt = vrcs_pkg::ST_SPEED;
      end
      vrcs_pkg::ST_SPEED: begin
        cmd.speed_calc = 1'b1;
        state_nxt = vrcs_pkg::ST_ROT;
      end
      vrcs_pkg::ST_ROT: begin
        cmd.rot_start = 1'b1;
        state_nxt = vrcs_pkg::ST_FIN;
      end
      vrcs_pkg::ST_FIN: begin
        if (stat.cordic_done) state_nxt = vrcs_pkg::ST_OUT;
      end
      vrcs_pkg::ST_OUT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt = vrcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vrcs_pkg::ST_IDLE;
    endcase
  end

  // a player check only starts from the target vectoring phase
  a_plr_from_tgt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.vec_plr_start |-> state_r == vrcs_pkg::ST_TGT)
    else $error("player vectoring started out of sequence");
  // a tick is accepted only when idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == vrcs_pkg::ST_SQ)
    else $error("load did not advance");
  // finishing returns to idle
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == vrcs_pkg::ST_IDLE)
    else $error("finish did not return to idle");

endmodule
`default_nettype wire

### rtl/vrcs_dp.sv
// vrcs_dp: datapath with squarer registers, bit serial square root,
// a shared cordic unit and the decision logic; depends on vrcs_pkg
`default_nettype none
module vrcs_dp #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  vrcs_pkg::cmd_t      cmd,
  output vrcs_pkg::stat_t     stat,
  input  wire logic [143:0]   in_item,
  input  wire logic [14:0]    speed_cap,
  input  wire logic [14:0]    speed_step,
  input  wire logic [14:0]    stop_speed,
  input  wire logic [14:0]    near_distance,
  input  wire logic [14:0]    moving_speed,
  input  wire logic [14:0]    cone_half_angle,
  output logic                coll_active,
  output logic signed [15:0]  cx,
  output logic signed [15:0]  cy,
  output logic                newly
);

  localparam int StepW = $clog2(CORDIC_STEPS + 1);
  localparam int Acc = 52;

  logic signed [15:0] rx_r, ry_r, tx_r, ty_r, vx_r, vy_r, px_r, py_r;
  logic [15:0] yaw_r;
  logic [31:0] vsq_r, dsq_r;
  logic [15:0] heading_r;
  logic coll_r, newly_r;

  // square root, two bits a cycle
  logic [31:0] sq_n_r;
  logic [31:0] sq_res_r;
  logic [31:0] sq_bit_r;
  logic sq_busy_r;

  // cordic
  logic signed [Acc-1:0] cx_r, cy_r;
  logic signed [17:0] cz_r;
  logic [15:0] cang_r;
  logic [StepW-1:0] ci_r;
  logic c_busy_r, c_rot_r, c_plr_r, c_stop_r, flip_r;
  logic [16:0] speed_r;

  logic [31:0] near_sq, mov_sq;
  assign near_sq = 32'(near_distance) * 32'(near_distance);
  assign mov_sq = 32'(moving_speed) * 32'(moving_speed);

  logic near_moving;
  assign near_moving = (dsq_r < near_sq) && (vsq_r > mov_sq);

  // cordic step
  logic [4:0] ci5;
  logic signed [Acc-1:0] shx, shy, nx, ny;
  logic [15:0] at;
  logic dir_pos;
  logic cdone;
  always_comb begin
    ci5 = 5'(ci_r);
    at = vrcs_pkg::atan_tab(ci5);
    shx = cx_r >>> ci5;
    shy = cy_r >>> ci5;
    dir_pos = c_rot_r ? (cz_r >= 0) : (cy_r > 0);
    if (c_rot_r ? dir_pos : dir_pos) begin
      if (c_rot_r) begin nx = cx_r - shy; ny = cy_r + shx; end
      else begin nx = cx_r + shy; ny = cy_r - shx; end
    end else begin
      if (c_rot_r) begin nx = cx_r + shy; ny = cy_r - shx; end
      else begin nx = cx_r - shy; ny = cy_r + shx; end
    end
    cdone = c_busy_r && ((32'(ci_r) >= CORDIC_STEPS) || ci5 >= 5'(vrcs_pkg::TableLen)
            || (!c_rot_r && cy_r == '0));
  end

  // vectoring start operands
  logic signed [16:0] vx0, vy0;
  always_comb begin
    if (cmd.vec_plr_start) begin
      vx0 = 17'(px_r); vy0 = 17'(py_r);
    end else begin
      vx0 = 17'(rx_r) - 17'(tx_r); vy0 = 17'(ry_r) - 17'(ty_r);
    end
  end

  // rotation start
  logic [16:0] a17;
  logic rflip;
  logic [15:0] ra;
  always_comb begin
    a17 = {1'b0, heading_r};
    rflip = (a17 > vrcs_pkg::QuarterTurn) &&
            (a17 < vrcs_pkg::HalfTurn + vrcs_pkg::QuarterTurn);
    ra = rflip ? heading_r + 16'h8000 : heading_r;
  end

  // speed
  logic signed [18:0] sp_dn, sp_up;
  always_comb begin
    sp_dn = 19'(sq_res_r[15:0]) - 19'(speed_step) * 19'sd3;
    sp_up = 19'(sq_res_r[15:0]) + 19'(speed_step);
  end

  // final rounding and saturation
  logic signed [Acc-1:0] rxf, ryf, rxs, rys;
  logic signed [15:0] sxo, syo;
  logic [31:0] csq, ssq;
  always_comb begin
    rxf = (cx_r + Acc'(32768)) >>> 16;
    ryf = (cy_r + Acc'(32768)) >>> 16;
    rxs = flip_r ? -rxf : rxf;
    rys = flip_r ? -ryf : ryf;
    sxo = (rxs > 32767) ? 16'sd32767 : (rxs < -32768) ? -16'sd32768 : 16'(rxs);
    syo = (rys > 32767) ? 16'sd32767 : (rys < -32768) ? -16'sd32768 : 16'(rys);
    csq = 32'(32'(sxo) * 32'(sxo)) + 32'(32'(syo) * 32'(syo));
    ssq = 32'(stop_speed) * 32'(stop_speed);
  end

  // player cone test
  logic [15:0] dang;
  logic in_cone;
  always_comb begin
    dang = cang_r - heading_r;
    if ({1'b0, dang} > vrcs_pkg::HalfTurn) dang = 16'(17'h10000 - {1'b0, dang});
    in_cone = {1'b0, dang} < {2'b0, cone_half_angle};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      {py_r, px_r, vy_r, vx_r, ty_r, tx_r, yaw_r, ry_r, rx_r} <= in_item;
    end
    if (cmd.sq_start) begin
      vsq_r <= 32'(32'(vx_r) * 32'(vx_r)) + 32'(32'(vy_r) * 32'(vy_r));
      dsq_r <= 32'(32'(px_r) * 32'(px_r)) + 32'(32'(py_r) * 32'(py_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sq_start) begin
      sq_busy_r <= 1'b1;
      sq_n_r <= 32'(32'(vx_r) * 32'(vx_r)) + 32'(32'(vy_r) * 32'(vy_r));
      sq_res_r <= '0;
      sq_bit_r <= 32'h4000_0000;
    end else if (sq_busy_r) begin
      if (sq_bit_r == '0) sq_busy_r <= 1'b0;
      else begin
        if (sq_n_r >= sq_res_r + sq_bit_r) begin
          sq_n_r <= sq_n_r - (sq_res_r + sq_bit_r);
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else sq_res_r <= sq_res_r >> 1;
        sq_bit_r <= sq_bit_r >> 2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_busy_r <= 1'b0;
      heading_r <= '0;
      coll_r <= 1'b0;
      newly_r <= 1'b0;
      c_stop_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        newly_r <= 1'b0;
        c_stop_r <= 1'b0;
      end
      if (cmd.vec_tgt_start || cmd.vec_plr_start) begin
        c_busy_r <= 1'b1;
        c_rot_r <= 1'b0;
        c_plr_r <= cmd.vec_plr_start;
        ci_r <= '0;
        cx_r <= (vx0 < 0) ? -(Acc'(vx0) <<< 12) : (Acc'(vx0) <<< 12);
        cy_r <= (vx0 < 0) ? -(Acc'(vy0) <<< 12) : (Acc'(vy0) <<< 12);
        cang_r <= (vx0 < 0) ? 16'h8000 : 16'h0000;
      end else if (cmd.rot_start) begin
        c_busy_r <= 1'b1;
        c_rot_r <= 1'b1;
        ci_r <= '0;
        flip_r <= rflip;
        cz_r <= 18'(signed'(ra));
        cx_r <= Acc'(32'(speed_r) * 32'(vrcs_pkg::GainInvQ16));
        cy_r <= '0;
      end else if (c_busy_r) begin
        if (cdone) begin
          c_busy_r <= 1'b0;
          if (!c_rot_r && c_plr_r && in_cone) begin
            coll_r <= 1'b1;
            newly_r <= 1'b1;
          end
          if (c_rot_r && csq < ssq) coll_r <= 1'b0;
        end else begin
          cx_r <= nx;
          cy_r <= ny;
          ci_r <= ci_r + 1'b1;
          if (c_rot_r) cz_r <= dir_pos ? cz_r - 18'(at) : cz_r + 18'(at);
          else cang_r <= dir_pos ? cang_r + at : cang_r - at;
        end
      end
      // heading taken as target vectoring ends, even when the player check starts at once
      if (cdone && !c_rot_r && !c_plr_r) heading_r <= cang_r + 16'h8000 - yaw_r;
    end
  end

  // braking mode follows the flag as it stood when the tick arrived
  always_ff @(posedge clk) begin
    if (cmd.speed_calc) begin
      if (coll_r && !newly_r) speed_r <= (sp_dn < 0) ? '0 : 17'(sp_dn);
      else speed_r <= (sp_up > 19'(speed_cap)) ? 17'(speed_cap) : 17'(sp_up);
    end
    if (cmd.finish) begin
      cx <= sxo;
      cy <= syo;
    end
  end

  assign stat.sqrt_done = sq_busy_r && sq_bit_r == '0;
  assign stat.cordic_done = cdone;
  assign stat.collision = coll_r;
  assign stat.near_moving = near_moving;
  assign coll_active = coll_r;
  assign newly = newly_r;

  a_newly_coll: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(newly_r) |-> c_plr_r)
    else $error("new collision without player check");
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rot_start |-> !c_busy_r))
    else $error("cordic restarted while busy");
  a_sqrt_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sq_start |=> sq_busy_r)
    else $error("square root did not start");

endmodule
`default_nettype wire

### rtl/velocity_ramp_with_collision_stop_unit.sv
// velocity_ramp_with_collision_stop_unit: top level, config registers,
// output register; depends on vrcs_pkg, vrcs_ctrl, vrcs_dp
//
// use: one request on in_* per control tick carries pose, target, measured
// velocity and player position; one request on out_* returns the commanded
// robot-frame velocity with braking and want_new_target flags in tuser
// cfg_we/cfg_idx/cfg_data write the six 15-bit registers while idle
// steps: load, squares, square root, then target vectoring and, while the
// player is near and the robot moving, player vectoring (neither runs
// while braking), speed update, rotation and the result; one tick at a time
// the result sits in an output register; in_tready rises once the result
// has been taken, so a stalled receiver holds the block with the request
// reset: registers back to defaults, heading 0, not braking, channels empty
`default_nettype none
module velocity_ramp_with_collision_stop_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // robot_x, robot_y, robot_yaw, target_x, target_y, meas_vel_x,
  // meas_vel_y, player_x, player_y
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // cmd_vel_x, cmd_vel_y
  output logic [31:0]       out_tdata,
  // braking, want_new_target
  output logic [1:0]        out_tuser,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_idx,
  input  wire logic [14:0]  cfg_data
);

  logic [14:0] speed_cap_r, speed_step_r, stop_speed_r, near_r, moving_r, cone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_cap_r <= 15'd179;
      speed_step_r <= 15'd13;
      stop_speed_r <= 15'd13;
      near_r <= 15'd256;
      moving_r <= 15'd13;
      cone_r <= 15'd3641;
    end else if (cfg_we) begin
      case (vrcs_pkg::reg_idx_t'(cfg_idx))
        vrcs_pkg::REG_SPEED_CAP: speed_cap_r <= cfg_data;
        vrcs_pkg::REG_SPEED_STEP: speed_step_r <= cfg_data;
        vrcs_pkg::REG_STOP_SPEED: stop_speed_r <= cfg_data;
        vrcs_pkg::REG_NEAR_DIST: near_r <= cfg_data;
        vrcs_pkg::REG_MOVING: moving_r <= cfg_data;
        vrcs_pkg::REG_CONE: cone_r <= cfg_data;
        default: ;
      endcase
    end
  end

  vrcs_pkg::cmd_t cmd;
  vrcs_pkg::stat_t stat;
  logic busy, coll, newly;
  logic signed [15:0] cx, cy;
  logic out_valid_r;
  logic fin_d_r;

  // nothing is taken while reset is held
  assign in_tready = rst_n && !busy && !out_valid_r;

  vrcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready),
    .out_free(!out_valid_r),
    .coll_active(coll),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  vrcs_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_item(in_tdata),
    .speed_cap(speed_cap_r), .speed_step(speed_step_r), .stop_speed(stop_speed_r),
    .near_distance(near_r), .moving_speed(moving_r), .cone_half_angle(cone_r),
    .coll_active(coll), .cx(cx), .cy(cy), .newly(newly)
  );

  // result register loaded on finish; flags are settled by then
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      fin_d_r <= 1'b0;
    end else begin
      fin_d_r <= cmd.finish;
      if (cmd.finish) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {cy, cx};
  assign out_tuser = {newly, coll};

  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_d_r |-> out_valid_r)
    else $error("result lost");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_tready)
    else $error("accepted while result pending");
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r)
    else $error("result overwritten");

endmodule
`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for velocity_ramp_with_collision_stop_unit
// drives control-tick requests, predicts each command and checks it; needs vrcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int Steps = 16;
  localparam int LimitCycles = 20000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [143:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [14:0] cfg_data;

  velocity_ramp_with_collision_stop_unit #(.CORDIC_STEPS(Steps)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // one control tick as it travels on in_tdata, lowest field first
  typedef struct {
    logic signed [15:0] rob_x, rob_y;
    logic [15:0] yaw;
    logic signed [15:0] tgt_x, tgt_y, vel_x, vel_y, ply_x, ply_y;
  } tick_t;

  typedef struct {
    logic signed [15:0] cmd_x, cmd_y;
    logic brake, retarget;
  } command_t;

  // predictor copy of registers and state
  logic [14:0] cap_speed, ramp_step, halt_speed, near_dist, move_speed, cone_half;
  logic [15:0] pred_heading;
  logic pred_braking;

  command_t cmd_queue[$];
  int errors;
  int idle_cycles;
  int send_idle_pct, recv_idle_pct;
  logic timed_out;

  // ---------------------------------------------------------------- helpers
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_root(longint n);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint arc_step(int i);
    return longint'(vrcs_pkg::atan_tab(5'(i)));
  endfunction

  // vectoring cordic: binary angle of (x, y)
  function automatic logic [15:0] bearing(longint x, longint y);
    logic [31:0] ang;
    longint nx;
    ang = 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'd32768;
    end
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (y == 0) break;
      if (y > 0) begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        ang = ang + 32'(arc_step(i));
      end else begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        ang = ang - 32'(arc_step(i));
      end
      x = nx;
    end
    return ang[15:0];
  endfunction

  function automatic longint clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rotation cordic: speed along angle, rounded and saturated
  function automatic void resolve(input longint mag, input logic [15:0] angle,
                                  output longint ox, output longint oy);
    longint a, z, x, y, nx, rx, ry;
    logic flip;
    a = longint'(angle);
    flip = 0;
    if (a > 16384 && a < 49152) begin
      flip = 1;
      a = (a + 32768) & 16'hFFFF;
    end
    z = (a >= 32768) ? a - 65536 : a;
    x = mag * 39797;
    y = 0;
    for (int i = 0; i < Steps && i < 24; i++) begin
      if (z >= 0) begin
        nx = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z = z - arc_step(i);
      end else begin
        nx = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z = z + arc_step(i);
      end
      x = nx;
    end
    rx = shr_floor(x + 32768, 16);
    ry = shr_floor(y + 32768, 16);
    if (flip) begin
      rx = -rx;
      ry = -ry;
    end
    ox = clip16(rx);
    oy = clip16(ry);
  endfunction

  // works out the command for one tick and advances the predictor state
  function automatic command_t predict_command(tick_t t);
    command_t c;
    longint vsq, meas, spd, dsq, cx, cy;
    logic [15:0] pdir, d;
    logic newly;
    newly = 0;
    vsq = longint'(t.vel_x) * t.vel_x + longint'(t.vel_y) * t.vel_y;
    meas = int_root(vsq);
    if (pred_braking) begin
      spd = meas - 3 * longint'(ramp_step);
      if (spd < 0) spd = 0;
    end else begin
      pred_heading = bearing(longint'(t.rob_x) - t.tgt_x, longint'(t.rob_y) - t.tgt_y)
                     + 16'd32768 - t.yaw;
      dsq = longint'(t.ply_x) * t.ply_x + longint'(t.ply_y) * t.ply_y;
      if (dsq < longint'(near_dist) * near_dist &&
          vsq > longint'(move_speed) * move_speed) begin
        pdir = bearing(t.ply_x, t.ply_y);
        d = pdir - pred_heading;
        if (d > 16'd32768) d = 16'd0 - d;
        if ({1'b0, d} < {2'b0, cone_half}) begin
          pred_braking = 1;
          newly = 1;
        end
      end
      spd = meas + longint'(ramp_step);
      if (spd > longint'(cap_speed)) spd = longint'(cap_speed);
    end
    resolve(spd, pred_heading, cx, cy);
    if (cx * cx + cy * cy < longint'(halt_speed) * halt_speed) pred_braking = 0;
    c.cmd_x = 16'(cx);
    c.cmd_y = 16'(cy);
    c.brake = pred_braking;
    c.retarget = newly;
    return c;
  endfunction

  // ---------------------------------------------------------------- clock, reset
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- drivers
  // tvalid stays up after a request until the next tick or an idle cycle
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tdata <= {t.ply_y, t.ply_x, t.vel_y, t.vel_x, t.tgt_y, t.tgt_x,
                 t.yaw, t.rob_y, t.rob_x};
    in_tvalid <= 1;
    cmd_queue.push_back(predict_command(t));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // write one register, mirror it in the predictor; caller drops cfg_we
  task automatic write_reg(input vrcs_pkg::reg_idx_t idx, input logic [14:0] val);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    case (idx)
      vrcs_pkg::REG_SPEED_CAP:  cap_speed = val;
      vrcs_pkg::REG_SPEED_STEP: ramp_step = val;
      vrcs_pkg::REG_STOP_SPEED: halt_speed = val;
      vrcs_pkg::REG_NEAR_DIST:  near_dist = val;
      vrcs_pkg::REG_MOVING:     move_speed = val;
      vrcs_pkg::REG_CONE:       cone_half = val;
      default: ;
    endcase
  endtask

  // every tick gives a result, so an empty queue means the block is idle
  task automatic drain;
    in_tvalid <= 0;
    while (cmd_queue.size() != 0 && !timed_out) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [15:0] any16();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] near16(int span);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  // a tick shaped to reach collisions: small player offset, moving robot
  function automatic tick_t shaped_tick();
    tick_t t;
    t.rob_x = near16(2000);
    t.rob_y = near16(2000);
    t.yaw = 16'($urandom);
    t.tgt_x = near16(2000);
    t.tgt_y = near16(2000);
    t.vel_x = near16(300);
    t.vel_y = near16(300);
    t.ply_x = near16(300);
    t.ply_y = near16(300);
    return t;
  endfunction

  function automatic tick_t wild_tick();
    tick_t t;
    t.rob_x = any16();
    t.rob_y = any16();
    t.yaw = any16();
    t.tgt_x = any16();
    t.tgt_y = any16();
    t.vel_x = any16();
    t.vel_y = any16();
    t.ply_x = any16();
    t.ply_y = any16();
    return t;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    command_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cmd_queue.size() == 0) begin
        $error("result with nothing expected: data %h user %b", out_tdata, out_tuser);
        errors++;
      end else begin
        e = cmd_queue.pop_front();
        if (out_tdata[15:0] !== e.cmd_x) begin
          $error("cmd_vel_x expected %0d got %0d", e.cmd_x, $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[31:16] !== e.cmd_y) begin
          $error("cmd_vel_y expected %0d got %0d", e.cmd_y, $signed(out_tdata[31:16]));
          errors++;
        end
        if (out_tuser[0] !== e.brake) begin
          $error("braking expected %0b got %0b", e.brake, out_tuser[0]);
          errors++;
        end
        if (out_tuser[1] !== e.retarget) begin
          $error("want_new_target expected %0b got %0b", e.retarget, out_tuser[1]);
          errors++;
        end
      end
    end
  end

  // receiver stalls at the chosen rate, changes on the falling edge
  always @(negedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // watchdog on cycles without any request moving
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > LimitCycles && !timed_out) begin
      timed_out = 1;
      $display("** velocity_ramp_with_collision_stop_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed;
    tick_t t;
    // target on robot, player on robot, all zero
    t = '{default: 16'h0};
    send_tick(t);
    // extremes of every field
    t = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
          16'h7FFF, 16'h8000};
    send_tick(t);
    t = '{16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
          16'h8000, 16'h7FFF};
    send_tick(t);
    // head-on player while moving: collision, then braking ticks
    t = '{16'd0, 16'd0, 16'd0, 16'd2560, 16'd0, 16'd200, 16'd0, 16'd40, 16'd0};
    repeat (3) send_tick(t);
    // player straight behind, sent while still braking: no new collision
    t.ply_x = -16'sd40;
    send_tick(t);
    // fast braking beyond range gives saturation
    t.ply_x = 16'd40;
    t.vel_x = 16'h8000;
    t.vel_y = 16'h8000;
    repeat (2) send_tick(t);
    drain();
  endtask

  task automatic test_set_and_clear;
    tick_t t;
    // large stop speed: flag is raised and cleared in the same tick
    write_reg(vrcs_pkg::REG_STOP_SPEED, 15'h7FFF);
    cfg_we <= 0;
    t = '{16'd0, 16'd0, 16'd0, 16'd2560, 16'd0, 16'd200, 16'd0, 16'd40, 16'd0};
    repeat (2) send_tick(t);
    drain();
  endtask

  task automatic run_random(input int n, input logic [14:0] ms, input logic [14:0] st,
                            input logic [14:0] sp, input logic [14:0] nd,
                            input logic [14:0] mv, input logic [14:0] cn);
    write_reg(vrcs_pkg::REG_SPEED_CAP, ms);
    write_reg(vrcs_pkg::REG_SPEED_STEP, st);
    write_reg(vrcs_pkg::REG_STOP_SPEED, sp);
    write_reg(vrcs_pkg::REG_NEAR_DIST, nd);
    write_reg(vrcs_pkg::REG_MOVING, mv);
    write_reg(vrcs_pkg::REG_CONE, cn);
    cfg_we <= 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) send_tick(shaped_tick());
      else send_tick(wild_tick());
    end
    drain();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    timed_out = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    cfg_we = 0;
    cfg_idx = vrcs_pkg::REG_SPEED_CAP;
    cfg_data = '0;
    cap_speed = 15'd179;
    ramp_step = 15'd13;
    halt_speed = 15'd13;
    near_dist = 15'd256;
    move_speed = 15'd13;
    cone_half = 15'd3641;
    pred_heading = 0;
    pred_braking = 0;
    send_idle_pct = 38;
    recv_idle_pct = 84;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    test_directed();
    test_set_and_clear();
    run_random(300, 15'd179, 15'd13, 15'd13, 15'd256, 15'd13, 15'd3641);
    run_random(250, 15'h7FFF, 15'h7FFF, 15'd0, 15'h7FFF, 15'd0, 15'h7FFF);
    send_idle_pct = 84;
    recv_idle_pct = 38;
    run_random(250, 15'd0, 15'd0, 15'd40, 15'd500, 15'd50, 15'd8000);
    run_random(250, 15'd400, 15'd60, 15'd20, 15'd300, 15'd10, 15'd16384);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(300, 15'd250, 15'd30, 15'd13, 15'd400, 15'd5, 15'd5000);
    run_random(280, 15'h2000, 15'd1, 15'd1, 15'd200, 15'h7FFF, 15'd0);

    if (errors == 0 && cmd_queue.size() == 0)
      $display("** velocity_ramp_with_collision_stop_unit: PASSED **");
    else
      $display("** velocity_ramp_with_collision_stop_unit: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
